@@ design/pfa_pkg.sv @@
// ----------------------------------------------------------------------------
// pfa_pkg: shared types and constants of the page frame allocator
// page geometry, field widths, operation and result codes, control structs
// ----------------------------------------------------------------------------
package pfa_pkg;

  // page geometry
  localparam int MAX_PAGES = 512;
  localparam int COUNT_W   = 8;
  localparam int PAGE_W    = $clog2(MAX_PAGES);
  localparam int FREE_W    = $clog2(MAX_PAGES + 1);

  // free bitmap is kept in words of WORD_W pages with one summary bit each
  localparam int WORD_W    = 32;
  localparam int BIT_W     = $clog2(WORD_W);
  localparam int WORDS     = MAX_PAGES / WORD_W;
  localparam int WIDX_W    = PAGE_W - BIT_W;

  // field and register widths
  localparam int MODE_W    = 2;
  localparam int STATUS_W  = 3;
  localparam int CFG_W     = 10;
  localparam int CFG_IDX_W = 1;
  localparam int LIM_W     = (CFG_W > FREE_W) ? CFG_W : FREE_W;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_FREE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL      = 1'b1;

  localparam logic [CFG_W-1:0] TOTAL_RESET = CFG_W'(512);

  typedef enum logic [MODE_W-1:0] {
    MODE_INIT    = 2'd0,
    MODE_ALLOC   = 2'd1,
    MODE_RELEASE = 2'd2,
    MODE_ADDREF  = 2'd3
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 3'd0,
    STAT_NO_FREE   = 3'd1,
    STAT_UNDERFLOW = 3'd2,
    STAT_SATURATED = 3'd3,
    STAT_RANGE     = 3'd4
  } stat_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_SWEEP,
    S_EXEC
  } fsm_t;

  // controller to datapath
  typedef struct packed {
    logic accept;       // capture the input word, launch memory reads
    logic sweep;        // walk one page of the sweep
    logic sweep_clear;  // sweep writes zero instead of the init pattern
    logic commit;       // finish the held operation, load the result
  } pfa_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic sweep_last;   // sweep is on the last page
    logic out_free;     // result register can take a new word
  } pfa_sts_t;

endpackage

@@ design/pfa_ram.sv @@
// ----------------------------------------------------------------------------
// pfa_ram: generic single write, single read memory
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module pfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ design/pfa_ctrl.sv @@
// ----------------------------------------------------------------------------
// pfa_ctrl: allocator controller
// sequences the clearing pass, input accept, init sweep and execute step
// ----------------------------------------------------------------------------
module pfa_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic [pfa_pkg::MODE_W-1:0]    in_mode,
  output logic                          in_stall,
  input  pfa_pkg::pfa_sts_t             sts,
  output pfa_pkg::pfa_cmd_t             cmd
);

  import pfa_pkg::*;

  fsm_t state_r;
  fsm_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        if (sts.sweep_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = (mode_t'(in_mode) == MODE_INIT) ? S_SWEEP : S_EXEC;
        end
      end
      S_SWEEP: begin
        if (sts.sweep_last) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (sts.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      S_CLEAR: begin
        cmd.sweep       = 1'b1;
        cmd.sweep_clear = 1'b1;
      end
      S_IDLE: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
      end
      S_SWEEP: begin
        cmd.sweep = 1'b1;
      end
      S_EXEC: begin
        cmd.commit = sts.out_free;
      end
      default: ;
    endcase
  end

endmodule

@@ design/pfa_dp.sv @@
// ----------------------------------------------------------------------------
// pfa_dp: allocator datapath
// count and bitmap memories, summary bits, free count, result register
// ----------------------------------------------------------------------------
module pfa_dp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  pfa_pkg::pfa_cmd_t               cmd,
  output pfa_pkg::pfa_sts_t               sts,
  input  logic [pfa_pkg::MODE_W-1:0]      in_mode,
  input  logic [pfa_pkg::PAGE_W-1:0]      in_page_number,
  input  logic                            cfg_we,
  input  logic [pfa_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pfa_pkg::CFG_W-1:0]       cfg_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [pfa_pkg::PAGE_W-1:0]      out_allocated_page,
  output logic [pfa_pkg::STATUS_W-1:0]    out_status,
  output logic [pfa_pkg::FREE_W-1:0]      out_pages_free
);

  import pfa_pkg::*;

  // lowest set summary bit
  function automatic logic [WIDX_W-1:0] first_word(input logic [WORDS-1:0] v);
    logic [WIDX_W-1:0] r;
    r = '0;
    for (int i = WORDS - 1; i >= 0; i--) begin
      if (v[i]) r = WIDX_W'(i);
    end
    return r;
  endfunction

  // lowest set bit of a bitmap word
  function automatic logic [BIT_W-1:0] first_bit(input logic [WORD_W-1:0] v);
    logic [BIT_W-1:0] r;
    r = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (v[i]) r = BIT_W'(i);
    end
    return r;
  endfunction

  // configuration
  logic [CFG_W-1:0] first_free_r;
  logic [CFG_W-1:0] total_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_free_r <= '0;
      total_r      <= TOTAL_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FIRST_FREE: first_free_r <= cfg_data;
        CFG_TOTAL:      total_r      <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [LIM_W-1:0] lim;
  logic [LIM_W-1:0] ffp;
  assign ffp = LIM_W'(first_free_r);
  assign lim = (LIM_W'(total_r) >= LIM_W'(MAX_PAGES)) ? LIM_W'(MAX_PAGES)
                                                      : LIM_W'(total_r);

  // held operation
  mode_t             mode_r;
  logic [PAGE_W-1:0] page_r;
  logic [WIDX_W-1:0] widx_r;
  logic [WIDX_W-1:0] acc_widx;

  logic [WORDS-1:0]  summary_r;
  logic [WORDS-1:0]  summary_nxt;
  logic [FREE_W-1:0] free_cnt_r;
  logic [FREE_W-1:0] free_cnt_nxt;
  logic [PAGE_W-1:0] sweep_r;
  logic [PAGE_W-1:0] sweep_nxt;

  assign acc_widx = (mode_t'(in_mode) == MODE_ALLOC) ? first_word(summary_r)
                                                     : in_page_number[PAGE_W-1:BIT_W];

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      mode_r <= mode_t'(in_mode);
      page_r <= in_page_number;
      widx_r <= acc_widx;
    end
  end

  // memories
  logic               cnt_we;
  logic [PAGE_W-1:0]  cnt_waddr;
  logic [COUNT_W-1:0] cnt_wdata;
  logic [PAGE_W-1:0]  cnt_raddr;
  logic [COUNT_W-1:0] cnt_rdata;

  logic               bm_we;
  logic [WIDX_W-1:0]  bm_waddr;
  logic [WORD_W-1:0]  bm_wdata;
  logic [WIDX_W-1:0]  bm_raddr;
  logic [WORD_W-1:0]  bm_rdata;

  assign cnt_raddr = cmd.accept ? in_page_number : page_r;
  assign bm_raddr  = cmd.accept ? acc_widx : widx_r;

  pfa_ram #(
    .WIDTH (COUNT_W),
    .DEPTH (MAX_PAGES)
  ) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .raddr (cnt_raddr),
    .rdata (cnt_rdata)
  );

  pfa_ram #(
    .WIDTH (WORD_W),
    .DEPTH (WORDS)
  ) u_bm_ram (
    .clk   (clk),
    .we    (bm_we),
    .waddr (bm_waddr),
    .wdata (bm_wdata),
    .raddr (bm_raddr),
    .rdata (bm_rdata)
  );

  // sweep pattern for init: free from first_free_page up to the limit
  logic [WORD_W-1:0]  init_mask;
  logic [WIDX_W-1:0]  sweep_w;
  logic [LIM_W-1:0]   sweep_page;
  logic [COUNT_W-1:0] sweep_cnt;
  logic               sweep_word;

  assign sweep_w    = sweep_r[PAGE_W-1:BIT_W];
  assign sweep_page = LIM_W'(sweep_r);
  assign sweep_word = (sweep_r[BIT_W-1:0] == '0);
  assign sweep_cnt  = (!cmd.sweep_clear && (sweep_page < ffp)) ? COUNT_W'(1) : '0;

  always_comb begin
    logic [LIM_W-1:0] p;
    for (int b = 0; b < WORD_W; b++) begin
      p = LIM_W'({sweep_w, BIT_W'(b)});
      init_mask[b] = !cmd.sweep_clear && (p >= ffp) && (p < lim);
    end
  end

  // execute step
  logic [WORD_W-1:0]  word_v;
  logic [BIT_W-1:0]   abit;
  logic [BIT_W-1:0]   rbit;
  logic               in_range;
  logic [FREE_W-1:0]  init_free;
  logic               ex_cnt_we;
  logic [PAGE_W-1:0]  ex_cnt_waddr;
  logic [COUNT_W-1:0] ex_cnt_wdata;
  logic               ex_bm_we;
  logic [WORD_W-1:0]  ex_bm_wdata;
  logic [FREE_W-1:0]  ex_free;
  logic [PAGE_W-1:0]  res_page;
  stat_t              res_stat;

  // a word whose summary bit is clear reads as all used
  assign word_v    = summary_r[widx_r] ? bm_rdata : '0;
  assign abit      = first_bit(word_v);
  assign rbit      = page_r[BIT_W-1:0];
  assign in_range  = LIM_W'(page_r) < lim;
  assign init_free = (ffp < lim) ? FREE_W'(lim - ffp) : '0;

  always_comb begin
    ex_cnt_we    = 1'b0;
    ex_cnt_waddr = page_r;
    ex_cnt_wdata = '0;
    ex_bm_we     = 1'b0;
    ex_bm_wdata  = word_v;
    ex_free      = free_cnt_r;
    res_page     = '0;
    res_stat     = STAT_OK;
    case (mode_r)
      MODE_INIT: begin
        ex_free = init_free;
      end
      MODE_ALLOC: begin
        if (free_cnt_r == '0) begin
          res_stat = STAT_NO_FREE;
        end else if (summary_r == '0) begin
          res_stat = STAT_NO_FREE;
          ex_free  = '0;
        end else begin
          ex_bm_we     = 1'b1;
          ex_bm_wdata  = word_v & ~(WORD_W'(1) << abit);
          ex_cnt_we    = 1'b1;
          ex_cnt_waddr = {widx_r, abit};
          ex_cnt_wdata = COUNT_W'(1);
          ex_free      = free_cnt_r - FREE_W'(1);
          res_page     = {widx_r, abit};
        end
      end
      MODE_RELEASE: begin
        if (!in_range) begin
          res_stat = STAT_RANGE;
        end else if (cnt_rdata == '0) begin
          res_stat = STAT_UNDERFLOW;
        end else begin
          ex_cnt_we    = 1'b1;
          ex_cnt_wdata = cnt_rdata - COUNT_W'(1);
          // last reference gone on a used page: free it
          if (cnt_rdata == COUNT_W'(1) && !word_v[rbit]) begin
            ex_bm_we    = 1'b1;
            ex_bm_wdata = word_v | (WORD_W'(1) << rbit);
            ex_free     = free_cnt_r + FREE_W'(1);
          end
        end
      end
      MODE_ADDREF: begin
        if (!in_range) begin
          res_stat = STAT_RANGE;
        end else if (cnt_rdata == {COUNT_W{1'b1}}) begin
          res_stat = STAT_SATURATED;
        end else begin
          ex_cnt_we    = 1'b1;
          ex_cnt_wdata = cnt_rdata + COUNT_W'(1);
        end
      end
      default: ;
    endcase
  end

  // memory write muxing between sweep and execute
  always_comb begin
    if (cmd.sweep) begin
      cnt_we    = 1'b1;
      cnt_waddr = sweep_r;
      cnt_wdata = sweep_cnt;
      bm_we     = sweep_word;
      bm_waddr  = sweep_w;
      bm_wdata  = init_mask;
    end else begin
      cnt_we    = cmd.commit && ex_cnt_we;
      cnt_waddr = ex_cnt_waddr;
      cnt_wdata = ex_cnt_wdata;
      bm_we     = cmd.commit && ex_bm_we;
      bm_waddr  = widx_r;
      bm_wdata  = ex_bm_wdata;
    end
  end

  // summary bit tracks a nonzero bitmap word
  always_comb begin
    summary_nxt = summary_r;
    if (bm_we) summary_nxt[bm_waddr] = |bm_wdata;
  end

  assign free_cnt_nxt = cmd.commit ? ex_free : free_cnt_r;
  assign sweep_nxt    = cmd.sweep ? sweep_r + PAGE_W'(1) : sweep_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      summary_r  <= '0;
      free_cnt_r <= '0;
      sweep_r    <= '0;
    end else begin
      summary_r  <= summary_nxt;
      free_cnt_r <= free_cnt_nxt;
      sweep_r    <= sweep_nxt;
    end
  end

  // result register
  logic              out_valid_r;
  logic              out_valid_nxt;
  logic [PAGE_W-1:0] out_page_r;
  stat_t             out_stat_r;
  logic [FREE_W-1:0] out_free_r;

  assign out_valid_nxt = cmd.commit ? 1'b1 : (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_page_r <= res_page;
      out_stat_r <= res_stat;
      out_free_r <= ex_free;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_allocated_page = out_page_r;
  assign out_status         = out_stat_r;
  assign out_pages_free     = out_free_r;

  assign sts.sweep_last = (sweep_r == PAGE_W'(MAX_PAGES - 1));
  assign sts.out_free   = !out_valid_r || !out_stall;

endmodule

@@ design/page_frame_allocator_refcount.sv @@
// ----------------------------------------------------------------------------
// page_frame_allocator_refcount: page frame allocator with reference counts
// free bitmap with summary bits, per page count memory, free page counter
// ----------------------------------------------------------------------------
// allocate, release and add reference: accept, then a read-modify-write execute on
//   the registered memory read, held while the result register is full; commit
//   loads the result word into the output register; in_stall stays high until then
// init: sweep over MAX_PAGES pages of the count memory (one a cycle), then execute
// reset: synchronous, rst_n low; then a clearing pass over all MAX_PAGES pages of
//   the count memory with in_stall high, configuration writes still taken
// ----------------------------------------------------------------------------
module page_frame_allocator_refcount (
  input  logic                            clk,
  input  logic                            rst_n,
  // input word
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [pfa_pkg::MODE_W-1:0]      in_mode,
  input  logic [pfa_pkg::PAGE_W-1:0]      in_page_number,
  // result word
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [pfa_pkg::PAGE_W-1:0]      out_allocated_page,
  output logic [pfa_pkg::STATUS_W-1:0]    out_status,
  output logic [pfa_pkg::FREE_W-1:0]      out_pages_free,
  // configuration write port
  input  logic                            cfg_we,
  input  logic [pfa_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pfa_pkg::CFG_W-1:0]       cfg_data
);

  import pfa_pkg::*;

  pfa_cmd_t cmd;
  pfa_sts_t sts;

  // controller: clear pass, accept, init sweep, execute
  pfa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_mode  (in_mode),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath: memories, summary bits, free count, result register
  pfa_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_mode            (in_mode),
    .in_page_number     (in_page_number),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_allocated_page (out_allocated_page),
    .out_status         (out_status),
    .out_pages_free     (out_pages_free)
  );

endmodule
